// ===== rtl/ptp_pkg.sv =====
// Shared constants for the three-point parabola coefficient unit.
`default_nettype none
package ptp_pkg;

  localparam int PORT_W         = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MUL_CHUNK      = 32;

endpackage
`default_nettype wire

// ===== rtl/ptp_mul.sv =====
// Two-stage signed multiplier built from chunk partial products.
`default_nettype none
module ptp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW = ptp_pkg::MUL_CHUNK;
  localparam int NC = (AW + CW - 1) / CW;
  localparam int EW = NC * CW;
  localparam int PW = CW + 1 + BW;
  localparam int SW = EW + BW + 1;

  logic signed [EW-1:0]    a_ext;
  logic signed [PW-1:0]    pp_r [NC];
  logic signed [SW-1:0]    sum_c;
  logic signed [AW+BW-1:0] p_r;

  assign a_ext = EW'(a);

  for (genvar k = 0; k < NC; k++) begin : g_chunk
    logic signed [CW:0] chunk;
    if (k == NC - 1) begin : g_top
      assign chunk = $signed({a_ext[EW-1], a_ext[k*CW +: CW]});
    end else begin : g_low
      assign chunk = $signed({1'b0, a_ext[k*CW +: CW]});
    end
    always_ff @(posedge clk) begin
      pp_r[k] <= chunk * b;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < NC; k++) begin
      sum_c = sum_c + (SW'(pp_r[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk) begin
    p_r <= sum_c[AW+BW-1:0];
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/parabola_through_three_points_unit.sv =====
// Top level: parabola coefficients a, b, c through three fixed-point points.
// Usage: the unit takes one item per clock (busy is always low) and returns its
// result strobed by out_valid for one cycle; results leave in acceptance order
// and cannot be held off. A restoring divider resolves one quotient bit per
// pipeline stage for the three coefficients side by side, after eleven stages
// that form the determinant and numerators exactly with chunked multipliers.
`default_nettype none
module parabola_through_three_points_unit #(
  parameter int DATA_WIDTH = ptp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptp_pkg::PORT_W-1:0]  in_x_first,
  input  logic [ptp_pkg::PORT_W-1:0]  in_x_second,
  input  logic [ptp_pkg::PORT_W-1:0]  in_x_third,
  input  logic [ptp_pkg::PORT_W-1:0]  in_y_first,
  input  logic [ptp_pkg::PORT_W-1:0]  in_y_second,
  input  logic [ptp_pkg::PORT_W-1:0]  in_y_third,
  output logic                        out_valid,
  output logic [ptp_pkg::PORT_W-1:0]  out_coef_square,
  output logic [ptp_pkg::PORT_W-1:0]  out_coef_linear,
  output logic [ptp_pkg::PORT_W-1:0]  out_coef_constant,
  output logic                        out_singular,
  output logic                        out_saturated
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int NA_W   = 2 * W + 3;
  localparam int NB_W   = 3 * W + 4;
  localparam int NC_W   = 4 * W + 3;
  localparam int DEN_W  = 3 * W + 4;
  localparam int NSA    = NA_W + 2 * F;
  localparam int NSB    = NB_W + F;
  localparam int NUM_AB = (NSA > NSB) ? NSA : NSB;
  localparam int NUM_W  = (NUM_AB > NC_W) ? NUM_AB : NC_W;
  localparam int NP_W   = NUM_W + 2;
  localparam int RW     = (NP_W > DEN_W + 1 + W) ? NP_W : DEN_W + 1 + W;
  localparam int NSTG   = W + 13;

  logic              accept;
  logic [NSTG-1:0]   vld_r;
  logic [NSTG-1:0]   vld_nxt;

  logic signed [W-1:0] xin [3];
  logic signed [W-1:0] yin [3];

  logic signed [W-1:0] x_s1_r [3];
  logic signed [W-1:0] y_s1_r [3];
  logic signed [W:0]   d_s1_r [3];
  logic signed [W-1:0] y_s2_r [3];
  logic signed [W:0]   d_s2_r [3];
  logic signed [W-1:0] y_s3_r [3];
  logic signed [W:0]   d_s3_r [3];

  logic signed [2*W-1:0] sq   [3];
  logic signed [2*W-1:0] xx   [3];
  logic signed [2*W:0]   ta   [3];
  logic signed [2*W+1:0] pd;

  logic signed [NA_W-1:0] na_s4_r;
  logic signed [2*W:0]    e_s4_r  [3];
  logic signed [2*W-1:0]  xx_s4_r [3];
  logic signed [2*W+1:0]  pd_s4_r;
  logic signed [W-1:0]    y_s4_r  [3];
  logic signed [W:0]      d_s4_r  [3];

  logic signed [3*W+2:0] detp;
  logic signed [3*W:0]   nbp [3];
  logic signed [3*W-1:0] ncp [3];

  logic signed [NA_W-1:0] na_s5_r;
  logic signed [W:0]      d_s5_r [3];
  logic signed [NA_W-1:0] na_s6_r;
  logic signed [W:0]      d_s6_r [3];

  logic signed [4*W:0]    ncf [3];

  logic signed [NA_W-1:0]  na_s7_r;
  logic signed [NB_W-1:0]  nb_s7_r;
  logic signed [DEN_W-1:0] det_s7_r;
  logic signed [NA_W-1:0]  na_s8_r;
  logic signed [NB_W-1:0]  nb_s8_r;
  logic signed [DEN_W-1:0] det_s8_r;
  logic signed [NA_W-1:0]  na_s9_r;
  logic signed [NB_W-1:0]  nb_s9_r;
  logic signed [NC_W-1:0]  nc_s9_r;
  logic signed [DEN_W-1:0] det_s9_r;

  logic signed [NUM_W-1:0] nsh [3];
  logic [NUM_W-1:0]        nm_s10_r  [3];
  logic                    neg_s10_r [3];
  logic [DEN_W-1:0]        dm_s10_r;
  logic                    sing_s10_r;

  logic [NP_W-1:0]   np_s11_r  [3];
  logic              neg_s11_r [3];
  logic [DEN_W:0]    dp_s11_r;
  logic              sing_s11_r;

  logic [RW-1:0]     rem_r  [W+1][3];
  logic [W-1:0]      quo_r  [W+1][3];
  logic              ovr_r  [W+1][3];
  logic              neg_r  [W+1][3];
  logic [DEN_W:0]    dp_r   [W+1];
  logic              sing_r [W+1];

  logic signed [W-1:0] coef_r [3];
  logic [2:0]          clip;
  logic                sing_o_r;
  logic                sat_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt = {vld_r[NSTG-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign xin[0] = in_x_first[W-1:0];
  assign xin[1] = in_x_second[W-1:0];
  assign xin[2] = in_x_third[W-1:0];
  assign yin[0] = in_y_first[W-1:0];
  assign yin[1] = in_y_second[W-1:0];
  assign yin[2] = in_y_third[W-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    localparam int IA = (k + 1) % 3;
    localparam int IB = (k + 2) % 3;

    always_ff @(posedge clk) begin
      x_s1_r[k] <= xin[k];
      y_s1_r[k] <= yin[k];
      d_s1_r[k] <= (W+1)'(xin[IA]) - (W+1)'(xin[IB]);
      y_s2_r[k] <= y_s1_r[k];
      d_s2_r[k] <= d_s1_r[k];
      y_s3_r[k] <= y_s2_r[k];
      d_s3_r[k] <= d_s2_r[k];
      e_s4_r[k]  <= (2*W+1)'(sq[IA]) - (2*W+1)'(sq[IB]);
      xx_s4_r[k] <= xx[k];
      y_s4_r[k]  <= y_s3_r[k];
      d_s4_r[k]  <= d_s3_r[k];
      d_s5_r[k]  <= d_s4_r[k];
      d_s6_r[k]  <= d_s5_r[k];
    end

    ptp_mul #(.AW(W), .BW(W)) u_sq (
      .clk(clk), .a(x_s1_r[k]), .b(x_s1_r[k]), .p(sq[k])
    );
    ptp_mul #(.AW(W), .BW(W)) u_xx (
      .clk(clk), .a(x_s1_r[IA]), .b(x_s1_r[IB]), .p(xx[k])
    );
    ptp_mul #(.AW(W + 1), .BW(W)) u_ta (
      .clk(clk), .a(d_s1_r[k]), .b(y_s1_r[k]), .p(ta[k])
    );
    ptp_mul #(.AW(2 * W + 1), .BW(W)) u_nbp (
      .clk(clk), .a(e_s4_r[k]), .b(y_s4_r[k]), .p(nbp[k])
    );
    ptp_mul #(.AW(2 * W), .BW(W)) u_ncp (
      .clk(clk), .a(xx_s4_r[k]), .b(y_s4_r[k]), .p(ncp[k])
    );
    ptp_mul #(.AW(3 * W), .BW(W + 1)) u_ncf (
      .clk(clk), .a(ncp[k]), .b(d_s6_r[k]), .p(ncf[k])
    );
  end

  ptp_mul #(.AW(W + 1), .BW(W + 1)) u_pd (
    .clk(clk), .a(d_s1_r[2]), .b(d_s1_r[1]), .p(pd)
  );
  ptp_mul #(.AW(2 * W + 2), .BW(W + 1)) u_det (
    .clk(clk), .a(pd_s4_r), .b(d_s4_r[0]), .p(detp)
  );

  always_ff @(posedge clk) begin
    na_s4_r  <= NA_W'(ta[0]) + NA_W'(ta[1]) + NA_W'(ta[2]);
    pd_s4_r  <= pd;
    na_s5_r  <= na_s4_r;
    na_s6_r  <= na_s5_r;
    na_s7_r  <= na_s6_r;
    nb_s7_r  <= -(NB_W'(nbp[0]) + NB_W'(nbp[1]) + NB_W'(nbp[2]));
    det_s7_r <= -DEN_W'(detp);
    na_s8_r  <= na_s7_r;
    nb_s8_r  <= nb_s7_r;
    det_s8_r <= det_s7_r;
    na_s9_r  <= na_s8_r;
    nb_s9_r  <= nb_s8_r;
    det_s9_r <= det_s8_r;
    nc_s9_r  <= NC_W'(ncf[0]) + NC_W'(ncf[1]) + NC_W'(ncf[2]);
  end

  assign nsh[0] = NUM_W'(na_s9_r) <<< (2 * F);
  assign nsh[1] = NUM_W'(nb_s9_r) <<< F;
  assign nsh[2] = NUM_W'(nc_s9_r);

  always_ff @(posedge clk) begin
    dm_s10_r   <= det_s9_r[DEN_W-1] ? DEN_W'(-det_s9_r) : DEN_W'(det_s9_r);
    sing_s10_r <= (det_s9_r == '0);
    dp_s11_r   <= {dm_s10_r, 1'b0};
    sing_s11_r <= sing_s10_r;
    dp_r[0]    <= dp_s11_r;
    sing_r[0]  <= sing_s11_r;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [RW-1:0] dtop;

    assign dtop = RW'(dp_s11_r) << W;

    always_ff @(posedge clk) begin
      nm_s10_r[k]  <= nsh[k][NUM_W-1] ? NUM_W'(-nsh[k]) : NUM_W'(nsh[k]);
      neg_s10_r[k] <= nsh[k][NUM_W-1] ^ det_s9_r[DEN_W-1];
      np_s11_r[k]  <= NP_W'({nm_s10_r[k], 1'b0}) + NP_W'(dm_s10_r);
      neg_s11_r[k] <= neg_s10_r[k];
      rem_r[0][k]  <= RW'(np_s11_r[k]);
      quo_r[0][k]  <= '0;
      ovr_r[0][k]  <= (RW'(np_s11_r[k]) >= dtop);
      neg_r[0][k]  <= neg_s11_r[k];
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int BI = W - 1 - j;

    always_ff @(posedge clk) begin
      dp_r[j+1]   <= dp_r[j];
      sing_r[j+1] <= sing_r[j];
    end

    for (genvar k = 0; k < 3; k++) begin : g_dl
      logic [RW-1:0] dsh;
      logic [RW:0]   dif;
      logic          ge;

      assign dsh = RW'(dp_r[j]) << BI;
      assign dif = {1'b0, rem_r[j][k]} - {1'b0, dsh};
      assign ge  = !dif[RW];

      always_ff @(posedge clk) begin
        rem_r[j+1][k] <= ge ? dif[RW-1:0] : rem_r[j][k];
        quo_r[j+1][k] <= quo_r[j][k] | (W'(ge) << BI);
        ovr_r[j+1][k] <= ovr_r[j][k];
        neg_r[j+1][k] <= neg_r[j][k];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sat
    logic [W-1:0] lim;
    logic [W-1:0] mag;

    assign lim     = {1'b0, {(W-1){1'b1}}} + W'(neg_r[W][k]);
    assign clip[k] = ovr_r[W][k] || (quo_r[W][k] > lim);
    assign mag     = clip[k] ? lim : quo_r[W][k];

    always_ff @(posedge clk) begin
      if (sing_r[W]) begin
        coef_r[k] <= '0;
      end else begin
        coef_r[k] <= neg_r[W][k] ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    sing_o_r <= sing_r[W];
    sat_r    <= (|clip) && !sing_r[W];
  end

  assign out_valid         = vld_r[NSTG-1];
  assign out_coef_square   = ptp_pkg::PORT_W'(coef_r[0]);
  assign out_coef_linear   = ptp_pkg::PORT_W'(coef_r[1]);
  assign out_coef_constant = ptp_pkg::PORT_W'(coef_r[2]);
  assign out_singular      = sing_o_r;
  assign out_saturated     = sat_r;

endmodule
`default_nettype wire

// ===== rtl/ptp_chk.sv =====
// Port-level checks for the parabola coefficient unit, bound to the top level.
`default_nettype none
module ptp_chk #(
  parameter int DATA_WIDTH = ptp_pkg::DATA_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ptp_pkg::PORT_W-1:0]  out_coef_square,
  input logic [ptp_pkg::PORT_W-1:0]  out_coef_linear,
  input logic [ptp_pkg::PORT_W-1:0]  out_coef_constant,
  input logic                        out_singular,
  input logic                        out_saturated
);

  localparam int LAT = DATA_WIDTH + 13;
  localparam logic [ptp_pkg::PORT_W-1:0] CMAX =
    ptp_pkg::PORT_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [ptp_pkg::PORT_W-1:0] CMIN = ~CMAX;

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("item result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without item");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_coef_square == '0 && out_coef_linear == '0 &&
      out_coef_constant == '0 && !out_saturated)
    else $error("singular result not cleared");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_coef_square == CMAX || out_coef_square == CMIN ||
      out_coef_linear == CMAX || out_coef_linear == CMIN ||
      out_coef_constant == CMAX || out_coef_constant == CMIN)
    else $error("saturated without clipped coefficient");

endmodule

bind parabola_through_three_points_unit ptp_chk #(.DATA_WIDTH(DATA_WIDTH)) u_ptp_chk (.*);
`default_nettype wire
